@@ rtl/vrc_pkg.sv @@
// Shared types and constants for the varint row codec.
// Used by vrc_step and by the top level vle_row_codec; depends on nothing.
package vrc_pkg;

   localparam int COL_W       = 5;   // column counter and column count width
   localparam int MAX_COLUMNS = 16;  // column count clamp

   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_ALL_ONES = 3'd1;
   localparam logic [2:0] ERR_ZERO_ENC = 3'd2;
   localparam logic [2:0] ERR_TOO_LONG = 3'd3;
   localparam logic [2:0] ERR_NO_TERM  = 3'd4;

   localparam logic [6:0] GROUP_MASK = 7'h7F;
   localparam logic [7:0] CONT_BIT   = 8'h80;
   localparam logic [7:0] NUL_BYTE   = 8'h00;

   // Row state carried from one item to the next
   typedef struct packed {
      logic [COL_W-1:0] col;
      logic [31:0]      acc;
      logic [2:0]       pos;
      logic             wait_term;
   } vrc_state_type;

   // Result list of one item: nbytes encoded bytes, then an optional tail beat
   typedef struct packed {
      logic [31:0] word;         // value+1 when encoding, decoded value when decoding
      logic [2:0]  nbytes;
      logic        tail;
      logic        tail_valid;
      logic        tail_row_end;
      logic [2:0]  tail_error;
   } vrc_desc_type;

endpackage

@@ rtl/vle_row_codec.sv @@
// Top level of the varint row codec: row state, work register and result register.
// Depends on vrc_pkg and vrc_step.
//
// Encodes rows of 32-bit values into offset LEB128 bytes closed by a NUL byte, or
// decodes such bytes back into values. Each input beat is worked out in the cycle it
// is accepted and its result list goes into a work register, which feeds one result
// beat a cycle into the output register unless the output stalls. A decode beat
// yields at most one result, so when the output does not stall decoding runs at
// one byte per cycle. An encode beat yields 1 to 6 result beats (5 bytes at most
// plus the row terminator) and holds the single result port until the last leaves;
// the next input beat is taken in the cycle that last beat leaves the work register.
// A configuration write clears the row state; csr_index 0 selects the direction
// (0 encode, 1 decode), 1 the column count (0 acts as 1, large values are clamped).
module vle_row_codec
   import vrc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // [31:0] value_in, [39:32] byte_in
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [7:0] byte_out, [39:8] value_out
   output logic [4:0]  rsp_tuser,   // [0] value_valid, [1] row_end, [4:2] error
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_index,
   input  logic [4:0]  csr_data
);

   localparam logic CSR_DIRECTION = 1'b0;
   localparam logic CSR_COLUMNS   = 1'b1;

   logic             dir_ff, dir_in;
   logic [COL_W-1:0] cnt_ff, cnt_in;
   vrc_state_type    st_ff, st_in, st_next;
   vrc_desc_type     wk_ff, wk_in, desc;
   logic             wk_valid_ff, wk_valid_in;
   logic [2:0]       beat_ff, beat_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       byte_ff, byte_in_nx;
   logic [31:0]      value_ff, value_in_nx;
   logic             vvalid_ff, vvalid_in;
   logic             rend_ff, rend_in;
   logic             last_ff, last_in;
   logic [2:0]       err_ff, err_in;

   logic             csr_we, accept, emit, beat_last;
   logic [2:0]       total, desc_total;
   logic [6:0]       group;
   logic [COL_W-1:0] cnt_clamped;

   vrc_step u_step (
      .dir        (dir_ff),
      .col_count  (cnt_ff),
      .state      (st_ff),
      .value_in   (req_tdata[31:0]),
      .byte_in    (req_tdata[39:32]),
      .state_next (st_next),
      .desc       (desc)
   );

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   always_comb begin
      priority if (csr_data == 5'd0) cnt_clamped = {{(COL_W-1){1'b0}}, 1'b1};
      else if ({1'b0, csr_data} > 6'(MAX_COLUMNS)) cnt_clamped = COL_W'(MAX_COLUMNS);
      else cnt_clamped = csr_data;
   end

   assign total      = wk_ff.nbytes + {2'd0, wk_ff.tail};
   assign desc_total = desc.nbytes + {2'd0, desc.tail};
   assign beat_last  = (beat_ff == total - 3'd1);
   assign emit       = wk_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !wk_valid_ff || (emit && beat_last);
   assign accept     = req_tvalid && req_tready;

   // configuration and row state
   always_comb begin
      dir_in = dir_ff;
      cnt_in = cnt_ff;
      st_in  = st_ff;
      if (csr_we) begin
         st_in = '0;
         unique case (csr_index)
            CSR_DIRECTION: dir_in = csr_data[0];
            CSR_COLUMNS:   cnt_in = cnt_clamped;
            default:       dir_in = dir_ff;
         endcase
      end else if (accept) begin
         st_in = st_next;
      end
   end

   // work register: hold the result list, advance one beat per emitted result
   always_comb begin
      wk_in       = wk_ff;
      wk_valid_in = wk_valid_ff;
      beat_in     = beat_ff;
      if (accept) begin
         wk_in       = desc;
         wk_valid_in = (desc_total != 3'd0);
         beat_in     = 3'd0;
      end else if (emit) begin
         if (beat_last) begin
            wk_valid_in = 1'b0;
         end else begin
            beat_in = beat_ff + 3'd1;
         end
      end
   end

   always_comb begin
      unique case (beat_ff)
         3'd0:    group = wk_ff.word[6:0];
         3'd1:    group = wk_ff.word[13:7];
         3'd2:    group = wk_ff.word[20:14];
         3'd3:    group = wk_ff.word[27:21];
         3'd4:    group = {3'd0, wk_ff.word[31:28]};
         default: group = 7'd0;
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      byte_in_nx   = byte_ff;
      value_in_nx  = value_ff;
      vvalid_in    = vvalid_ff;
      rend_in      = rend_ff;
      last_in      = last_ff;
      err_in       = err_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
         if (beat_ff < wk_ff.nbytes) begin
            byte_in_nx = {1'b0, group & GROUP_MASK};
            if (beat_ff != wk_ff.nbytes - 3'd1) begin
               byte_in_nx = byte_in_nx | CONT_BIT;
            end
            value_in_nx = 32'd0;
            vvalid_in   = 1'b0;
            rend_in     = 1'b0;
            last_in     = beat_last;
            err_in      = ERR_NONE;
         end else begin
            byte_in_nx  = NUL_BYTE;
            value_in_nx = wk_ff.tail_valid ? wk_ff.word : 32'd0;
            vvalid_in   = wk_ff.tail_valid;
            rend_in     = wk_ff.tail_row_end;
            last_in     = 1'b1;
            err_in      = wk_ff.tail_error;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff       <= 1'b0;
         cnt_ff       <= {{(COL_W-1){1'b0}}, 1'b1};
         st_ff        <= '0;
         wk_valid_ff  <= 1'b0;
         beat_ff      <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         dir_ff       <= dir_in;
         cnt_ff       <= cnt_in;
         st_ff        <= st_in;
         wk_valid_ff  <= wk_valid_in;
         beat_ff      <= beat_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      wk_ff     <= wk_in;
      byte_ff   <= byte_in_nx;
      value_ff  <= value_in_nx;
      vvalid_ff <= vvalid_in;
      rend_ff   <= rend_in;
      last_ff   <= last_in;
      err_ff    <= err_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {value_ff, byte_ff};
   assign rsp_tuser  = {err_ff, rend_ff, vvalid_ff};
   assign rsp_tlast  = last_ff;

endmodule

@@ rtl/vrc_step.sv @@
// Per-item step of the varint row codec: next row state and the result list.
// Pure combinational logic; depends on vrc_pkg.
module vrc_step
   import vrc_pkg::*;
(
   input  logic             dir,
   input  logic [COL_W-1:0] col_count,
   input  vrc_state_type    state,
   input  logic [31:0]      value_in,
   input  logic [7:0]       byte_in,
   output vrc_state_type    state_next,
   output vrc_desc_type     desc
);

   logic [31:0]      v_inc;
   logic [31:0]      group_shifted;
   logic [31:0]      acc_new;
   logic [COL_W-1:0] col_inc;
   logic             row_done;

   assign v_inc   = value_in + 32'd1;
   assign col_inc = state.col + {{(COL_W-1){1'b0}}, 1'b1};
   assign row_done = (col_inc >= col_count);

   always_comb begin
      unique case (state.pos)
         3'd0:    group_shifted = {25'd0, byte_in[6:0]};
         3'd1:    group_shifted = {18'd0, byte_in[6:0], 7'd0};
         3'd2:    group_shifted = {11'd0, byte_in[6:0], 14'd0};
         3'd3:    group_shifted = {4'd0, byte_in[6:0], 21'd0};
         3'd4:    group_shifted = {byte_in[3:0], 28'd0};
         default: group_shifted = 32'd0;
      endcase
   end

   assign acc_new = state.acc | group_shifted;

   always_comb begin
      state_next        = state;
      desc.word         = 32'd0;
      desc.nbytes       = 3'd0;
      desc.tail         = 1'b0;
      desc.tail_valid   = 1'b0;
      desc.tail_row_end = 1'b0;
      desc.tail_error   = ERR_NONE;
      if (!dir) begin
         if (v_inc == 32'd0) begin
            state_next      = '0;
            desc.tail       = 1'b1;
            desc.tail_error = ERR_ALL_ONES;
         end else begin
            desc.word = v_inc;
            priority if (v_inc[31:7] == 25'd0)  desc.nbytes = 3'd1;
            else if (v_inc[31:14] == 18'd0)     desc.nbytes = 3'd2;
            else if (v_inc[31:21] == 11'd0)     desc.nbytes = 3'd3;
            else if (v_inc[31:28] == 4'd0)      desc.nbytes = 3'd4;
            else                                desc.nbytes = 3'd5;
            // close the row with a NUL beat after the last column
            if (row_done) begin
               state_next.col    = '0;
               desc.tail         = 1'b1;
               desc.tail_row_end = 1'b1;
            end else begin
               state_next.col = col_inc;
            end
         end
      end else begin
         if (state.wait_term) begin
            state_next = '0;
            desc.tail  = 1'b1;
            if (byte_in == NUL_BYTE) begin
               desc.tail_row_end = 1'b1;
            end else begin
               desc.tail_error = ERR_NO_TERM;
            end
         end else if ((byte_in & CONT_BIT) != 8'd0) begin
            if (state.pos >= 3'd4) begin
               state_next      = '0;
               desc.tail       = 1'b1;
               desc.tail_error = ERR_TOO_LONG;
            end else begin
               state_next.acc = acc_new;
               state_next.pos = state.pos + 3'd1;
            end
         end else if (acc_new == 32'd0) begin
            state_next      = '0;
            desc.tail       = 1'b1;
            desc.tail_error = ERR_ZERO_ENC;
         end else begin
            state_next.acc  = 32'd0;
            state_next.pos  = 3'd0;
            desc.word       = acc_new - 32'd1;
            desc.tail       = 1'b1;
            desc.tail_valid = 1'b1;
            if (row_done) begin
               state_next.col       = '0;
               state_next.wait_term = 1'b1;
            end else begin
               state_next.col = col_inc;
            end
         end
      end
   end

endmodule
